FILE: hw/rtl/lwcd_pkg.sv
// ----------------------------------------------------------------------------
// lwcd_pkg: shared types and codes of the lock-wait cycle detector
// Event codes, the sequencer state type and the control bundle that the
// sequencer sends to the table storage.
// ----------------------------------------------------------------------------
package lwcd_pkg;

    localparam logic [2:0] MODE_ADD_WAIT   = 3'd0;
    localparam logic [2:0] MODE_REM_WAIT   = 3'd1;
    localparam logic [2:0] MODE_SET_HOLDER = 3'd2;
    localparam logic [2:0] MODE_RELEASE    = 3'd3;
    localparam logic [2:0] MODE_CHECK      = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ROW_WR,
        ST_CHK_EVAL,
        ST_PICK,
        ST_SCAN,
        ST_DRAIN,
        ST_RESP
    } state_t;

    // Strobes from the sequencer to the storage.
    typedef struct packed {
        logic held_set;
        logic held_clr;
        logic own_we;
        logic own_re;
        logic row_we;
        logic row_re;
    } store_ctl_t;

endpackage

FILE: hw/rtl/lwcd_store.sv
// ----------------------------------------------------------------------------
// lwcd_store: lock and wait tables
// Holds the lock-held flags, the lock-owner memory and the per-thread wait
// bitmap memory with one valid flag per row.
// ----------------------------------------------------------------------------
module lwcd_store #(
    parameter int THREADS = 16,
    parameter int LOCKS   = 64,
    parameter int TW      = 4,
    parameter int LW      = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lwcd_pkg::store_ctl_t ctl,
    input  logic [LW-1:0]        lock_addr,
    input  logic [TW-1:0]        thr_addr,
    input  logic [TW-1:0]        own_wdata,
    input  logic [LOCKS-1:0]     row_wdata,
    output logic                 held_out,
    output logic [TW-1:0]        own_rdata,
    output logic [LOCKS-1:0]     row_rdata
);

    logic [LOCKS-1:0]   held_reg;
    logic [THREADS-1:0] row_vld_reg;
    logic [TW-1:0]      own_mem [LOCKS];
    logic [LOCKS-1:0]   row_mem [THREADS];
    logic [TW-1:0]      own_rd_reg;
    logic [LOCKS-1:0]   row_rd_reg;
    logic               row_rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= '0;
            row_vld_reg <= '0;
        end else begin
            if (ctl.held_set) begin
                held_reg[lock_addr] <= 1'b1;
            end else if (ctl.held_clr) begin
                held_reg[lock_addr] <= 1'b0;
            end
            if (ctl.row_we) begin
                row_vld_reg[thr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.own_we) begin
            own_mem[lock_addr] <= own_wdata;
        end
        if (ctl.own_re) begin
            own_rd_reg <= own_mem[lock_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.row_we) begin
            row_mem[thr_addr] <= row_wdata;
        end
        if (ctl.row_re) begin
            row_rd_reg     <= row_mem[thr_addr];
            row_rd_vld_reg <= row_vld_reg[thr_addr];
        end
    end

    // A row never written since reset reads as all zero.
    assign held_out  = held_reg[lock_addr];
    assign own_rdata = own_rd_reg;
    assign row_rdata = row_rd_vld_reg ? row_rd_reg : '0;

endmodule

FILE: hw/rtl/lock_wait_cycle_detector_core.sv
// Timing: an update passes the decode state, a row write for wait changes and the
// response state; a check may end early, and otherwise its length is set by the
// one-lock-per-cycle scan of each visited thread's wait row. A busy output
// register adds its wait on top.
// Throughput: one item at a time; the next input transfer is taken in the idle
// cycle after the result is registered.
// Reset: aresetn low clears all lock-held and wait bits and the output valid.
// ----------------------------------------------------------------------------
// lock_wait_cycle_detector_core: wait-for graph deadlock detector
// Keeps lock ownership and per-thread wait bitmaps, and answers whether a
// thread taking a lock would close a wait cycle by walking the graph with a
// shared owner-compare unit under a small sequencer.
// ----------------------------------------------------------------------------
module lock_wait_cycle_detector_core #(
    parameter int THREADS = 16,
    parameter int LOCKS   = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_mode,
    input  logic [3:0] s_thread,
    input  logic [5:0] s_lock,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_would_deadlock
);

    localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int LW = (LOCKS > 1) ? $clog2(LOCKS) : 1;

    lwcd_pkg::state_t state_reg, state_next;

    // Fields of the item in progress, captured at the input transfer.
    logic [2:0] mode_reg, mode_next;
    logic [3:0] self_reg, self_next;
    logic [5:0] lock_reg, lock_next;
    logic       ok_reg, ok_next;       // thread and lock both in range
    logic       lk_ok_reg, lk_ok_next; // lock in range
    logic       ans_reg, ans_next;

    // Walk state: visited threads, threads still to expand, sweep pointers.
    logic [THREADS-1:0] seen_reg, seen_next;
    logic [THREADS-1:0] front_reg, front_next;
    logic [TW-1:0]      tptr_reg, tptr_next;
    logic [LW-1:0]      lptr_reg, lptr_next;
    logic               cand_reg, cand_next;

    logic m_valid_reg, m_valid_next;
    logic m_data_reg, m_data_next;

    lwcd_pkg::store_ctl_t ctl;
    logic [LW-1:0]        lock_addr;
    logic [TW-1:0]        thr_addr;
    logic [LOCKS-1:0]     row_wdata;
    logic                 held_out;
    logic [TW-1:0]        own_rdata;
    logic [LOCKS-1:0]     row_rdata;

    // Shared compare unit: judges the owner fetched for the previous lock.
    logic               hit;
    logic               new_thr;
    logic [THREADS-1:0] own_onehot;
    logic [LOCKS-1:0]   lock_sel;
    logic [TW-1:0]      tptr_inc;

    lwcd_store #(
        .THREADS (THREADS),
        .LOCKS   (LOCKS),
        .TW      (TW),
        .LW      (LW)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .lock_addr (lock_addr),
        .thr_addr  (thr_addr),
        .own_wdata (TW'(self_reg)),
        .row_wdata (row_wdata),
        .held_out  (held_out),
        .own_rdata (own_rdata),
        .row_rdata (row_rdata)
    );

    assign own_onehot = THREADS'(1) << own_rdata;
    assign hit        = cand_reg && (own_rdata == TW'(self_reg));
    assign new_thr    = cand_reg && !seen_reg[own_rdata];
    assign lock_sel   = LOCKS'(1) << LW'(lock_reg);
    assign row_wdata  = (mode_reg == lwcd_pkg::MODE_ADD_WAIT) ? (row_rdata | lock_sel)
                                                             : (row_rdata & ~lock_sel);
    assign tptr_inc   = (tptr_reg == TW'(THREADS - 1)) ? '0 : tptr_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lwcd_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        self_reg   <= self_next;
        lock_reg   <= lock_next;
        ok_reg     <= ok_next;
        lk_ok_reg  <= lk_ok_next;
        ans_reg    <= ans_next;
        seen_reg   <= seen_next;
        front_reg  <= front_next;
        tptr_reg   <= tptr_next;
        lptr_reg   <= lptr_next;
        cand_reg   <= cand_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        self_next    = self_reg;
        lock_next    = lock_reg;
        ok_next      = ok_reg;
        lk_ok_next   = lk_ok_reg;
        ans_next     = ans_reg;
        seen_next    = seen_reg;
        front_next   = front_reg;
        tptr_next    = tptr_reg;
        lptr_next    = lptr_reg;
        cand_next    = cand_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ctl          = '0;
        lock_addr    = LW'(lock_reg);
        thr_addr     = TW'(self_reg);

        case (state_reg)
            lwcd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    mode_next  = s_mode;
                    self_next  = s_thread;
                    lock_next  = s_lock;
                    ok_next    = (32'(s_thread) < 32'(THREADS)) && (32'(s_lock) < 32'(LOCKS));
                    lk_ok_next = 32'(s_lock) < 32'(LOCKS);
                    ans_next   = 1'b0;
                    state_next = lwcd_pkg::ST_DECODE;
                end
            end

            lwcd_pkg::ST_DECODE: begin
                state_next = lwcd_pkg::ST_RESP;
                case (mode_reg)
                    lwcd_pkg::MODE_ADD_WAIT, lwcd_pkg::MODE_REM_WAIT: begin
                        // Read-modify-write of the thread's wait row.
                        if (ok_reg) begin
                            ctl.row_re = 1'b1;
                            state_next = lwcd_pkg::ST_ROW_WR;
                        end
                    end
                    lwcd_pkg::MODE_SET_HOLDER: begin
                        if (ok_reg) begin
                            ctl.held_set = 1'b1;
                            ctl.own_we   = 1'b1;
                        end
                    end
                    lwcd_pkg::MODE_RELEASE: begin
                        ctl.held_clr = lk_ok_reg;
                    end
                    lwcd_pkg::MODE_CHECK: begin
                        // A lock nobody holds cannot close a cycle.
                        if (ok_reg && held_out) begin
                            ctl.own_re = 1'b1;
                            state_next = lwcd_pkg::ST_CHK_EVAL;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            lwcd_pkg::ST_ROW_WR: begin
                ctl.row_we = 1'b1;
                state_next = lwcd_pkg::ST_RESP;
            end

            lwcd_pkg::ST_CHK_EVAL: begin
                // The holder of the requested lock is either the requester
                // itself or the first thread of the walk.
                if (own_rdata == TW'(self_reg)) begin
                    ans_next   = 1'b1;
                    state_next = lwcd_pkg::ST_RESP;
                end else begin
                    front_next = own_onehot;
                    seen_next  = '0;
                    tptr_next  = '0;
                    state_next = lwcd_pkg::ST_PICK;
                end
            end

            lwcd_pkg::ST_PICK: begin
                // Sweep the frontier one thread per cycle, pausing while a picked thread's
                // row is scanned, wrapping around, until it runs empty.
                cand_next = 1'b0;
                thr_addr  = tptr_reg;
                if (front_reg == '0) begin
                    state_next = lwcd_pkg::ST_RESP;
                end else if (front_reg[tptr_reg]) begin
                    front_next[tptr_reg] = 1'b0;
                    if (seen_reg[tptr_reg]) begin
                        tptr_next = tptr_inc;
                    end else begin
                        seen_next[tptr_reg] = 1'b1;
                        ctl.row_re = 1'b1;
                        lptr_next  = '0;
                        state_next = lwcd_pkg::ST_SCAN;
                    end
                end else begin
                    tptr_next = tptr_inc;
                end
            end

            lwcd_pkg::ST_SCAN: begin
                // One lock per cycle: fetch the owner of a waited, held lock
                // while the owner fetched in the previous cycle is judged.
                lock_addr  = lptr_reg;
                cand_next  = row_rdata[lptr_reg] && held_out;
                ctl.own_re = cand_next;
                if (new_thr) begin
                    front_next = front_reg | own_onehot;
                end
                lptr_next = lptr_reg + 1'b1;
                if (hit) begin
                    ans_next   = 1'b1;
                    state_next = lwcd_pkg::ST_RESP;
                end else if (lptr_reg == LW'(LOCKS - 1)) begin
                    state_next = lwcd_pkg::ST_DRAIN;
                end
            end

            lwcd_pkg::ST_DRAIN: begin
                cand_next = 1'b0;
                if (new_thr) begin
                    front_next = front_reg | own_onehot;
                end
                if (hit) begin
                    ans_next   = 1'b1;
                    state_next = lwcd_pkg::ST_RESP;
                end else begin
                    tptr_next  = tptr_inc;
                    state_next = lwcd_pkg::ST_PICK;
                end
            end

            lwcd_pkg::ST_RESP: begin
                // The output register takes the answer once it is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = ans_reg;
                    state_next   = lwcd_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = lwcd_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_ready          = (state_reg == lwcd_pkg::ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_would_deadlock = m_data_reg;

endmodule
